>>> sv/dhm_pkg.sv
// Shared types and codes for the double-hashing open-address map.
`timescale 1ns / 1ps

package dhm_pkg;

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_PSTART,
        S_PROBE,
        S_CLEAR,
        S_GATHER,
        S_RLOAD,
        S_RSTART,
        S_RPROBE,
        S_RESULT
    } state_t;

    localparam logic [31:0] TAG_EMPTY = 32'd0;
    localparam logic [31:0] TAG_TOMB  = 32'd1;
    localparam int          TAG_LIVE_BIT = 1;

endpackage

>>> sv/dhm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/double_hash_open_address_map.sv
// Top level: open-address hash map with double hashing, kept in synchronous RAMs.
// Find and remove: accept, dispatch, start the probe, then probe slot by slot to the result.
// Insert: same, after a rebuild when growth or rehash is due; a remove may rebuild to shrink.
// A rebuild sweeps the old table (one slot per cycle) and re-places each live item by probing.
// Removing the last item clears the table, one slot per cycle; one item is in flight at a time.
// After reset the tag RAM is swept, all 2^MAX_INDEX_BITS slots, while input stays stalled.
`timescale 1ns / 1ps

module double_hash_open_address_map
    import dhm_pkg::*;
#(
    parameter int MAX_INDEX_BITS = 10,
    parameter int MIN_INDEX_BITS = 4,
    parameter int KEY_WIDTH      = 32,
    parameter int VALUE_WIDTH    = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              opcode,
    input  logic [31:0]             key,
    input  logic [31:0]             key_hash,
    input  logic [31:0]             value_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic [31:0]             value_out,
    output logic [MAX_INDEX_BITS:0] entry_count
);

    localparam int AW    = MAX_INDEX_BITS;
    localparam int CW    = MAX_INDEX_BITS + 1;
    localparam int IBW   = $clog2(MAX_INDEX_BITS + 1);
    localparam int SLOTS = 1 << MAX_INDEX_BITS;
    localparam int KW    = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int VW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int KVW   = KW + VW;
    localparam int SW    = 32 + KVW;
    localparam logic [CW-1:0]  EMPTY_RST = CW'(1) << MIN_INDEX_BITS;
    localparam logic [CW-1:0]  SLOTS_M1  = CW'(SLOTS - 1);
    localparam logic [IBW-1:0] IB_MIN    = IBW'(MIN_INDEX_BITS);
    localparam logic [IBW-1:0] IB_MAX    = IBW'(MAX_INDEX_BITS);

    function automatic logic [AW-1:0] start_ix(input logic [31:0] t, input logic [IBW-1:0] ib);
        logic [5:0] sh;
        sh = 6'd32 - 6'(ib);
        return AW'(t >> sh);
    endfunction

    // control registers
    state_t         state_reg, state_next;
    logic [IBW-1:0] ib_reg, ib_next;
    logic           gen_reg, gen_next;
    logic [CW-1:0]  live_reg, live_next;
    logic [CW-1:0]  empty_reg, empty_next;
    logic [CW-1:0]  c_reg, c_next;
    logic           pend_reg, pend_next;
    logic           out_valid_reg, out_valid_next;

    // payload registers
    op_t            op_reg, op_next;
    logic [KW-1:0]  key_reg, key_next;
    logic [31:0]    hash_reg, hash_next;
    logic [VW-1:0]  val_reg, val_next;
    logic [IBW-1:0] nb_reg, nb_next;
    logic [AW-1:0]  ix_reg, ix_next;
    logic [AW-1:0]  cnt_reg, cnt_next;
    logic [31:0]    pt_reg, pt_next;
    logic           tomb_v_reg, tomb_v_next;
    logic [AW-1:0]  tomb_ix_reg, tomb_ix_next;
    logic [CW-1:0]  g_reg, g_next;
    logic [AW-1:0]  paddr_reg, paddr_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [KVW-1:0] rkv_reg, rkv_next;
    status_t        res_status_reg, res_status_next;
    logic [VW-1:0]  res_value_reg, res_value_next;
    status_t        out_status_reg, out_status_next;
    logic [VW-1:0]  out_value_reg, out_value_next;
    logic [CW-1:0]  out_count_reg, out_count_next;

    // memory ports
    logic           tag_we, kv_we, sc_we;
    logic [AW-1:0]  tag_waddr, kv_waddr, rd_addr;
    logic [31:0]    tag_wdata, tag_q;
    logic [KVW-1:0] kv_wdata, kv_q;
    logic [SW-1:0]  sc_q;

    // datapath terms
    logic [CW-1:0]  size_w, upper_w, lower_w, live_dec;
    logic [AW-1:0]  mask_w, step_w, ix_adv, pstart_ix, rstart_ix;
    logic [31:0]    t_w, rt_w;
    logic           tag_empty, tag_tomb, key_match, last_probe, probe_end;
    logic           grow, rehash, old_done, ins_tomb_now, have_tomb, take_empty, out_free;

    assign size_w     = CW'(1) << ib_reg;
    assign mask_w     = AW'(size_w - CW'(1));
    assign upper_w    = (size_w >> 1) + (size_w >> 2);
    assign lower_w    = (ib_reg <= IB_MIN) ? '0 : (size_w >> 2);
    assign live_dec   = live_reg - CW'(1);
    assign t_w        = {hash_reg[31:2], 1'b1, gen_reg};
    assign rt_w       = {sc_q[SW-1 -: 30], 1'b1, gen_reg};
    assign pstart_ix  = start_ix(t_w, ib_reg);
    assign rstart_ix  = start_ix(rt_w, ib_reg);
    assign step_w     = AW'(pt_reg >> 1) & mask_w;
    assign ix_adv     = (ix_reg + step_w) & mask_w;
    assign tag_empty  = (tag_q == TAG_EMPTY);
    assign tag_tomb   = (tag_q == TAG_TOMB);
    assign key_match  = (tag_q == pt_reg) && (kv_q[KVW-1:VW] == key_reg);
    assign last_probe = (cnt_reg == mask_w);
    assign probe_end  = tag_empty || last_probe;
    assign grow       = (ib_reg < IB_MAX) && (live_reg > upper_w);
    assign rehash     = (empty_reg < (size_w >> 3));
    assign old_done   = (g_reg == size_w) && !pend_reg;
    assign ins_tomb_now = tag_tomb && !tomb_v_reg;
    assign have_tomb  = tomb_v_reg || ins_tomb_now;
    assign take_empty = tag_empty && !tomb_v_reg && (empty_reg > CW'(1));
    assign out_free   = !out_valid_reg || !out_stall;

    dhm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (rd_addr),
        .rdata (tag_q)
    );

    dhm_ram #(.WIDTH(KVW), .DEPTH(SLOTS)) u_kv_ram (
        .clk   (clk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (kv_wdata),
        .raddr (rd_addr),
        .rdata (kv_q)
    );

    // scratch list of live items during a rebuild
    dhm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_sc_ram (
        .clk   (clk),
        .we    (sc_we),
        .waddr (n_reg[AW-1:0]),
        .wdata ({tag_q, kv_q}),
        .raddr (k_reg[AW-1:0]),
        .rdata (sc_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (c_reg == SLOTS_M1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_INSERT:           state_next = (grow || rehash) ? S_GATHER : S_PSTART;
                    OP_FIND, OP_REMOVE:  state_next = S_PSTART;
                    default:             state_next = S_RESULT;
                endcase
            end
            S_PSTART:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (op_reg == OP_REMOVE && key_match)
                begin
                    if (live_dec == '0)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (live_dec < lower_w)
                    begin
                        state_next = S_GATHER;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else if (key_match || probe_end)
                begin
                    state_next = S_RESULT;
                end
            end
            S_CLEAR:
            begin
                if (c_reg == size_w - CW'(1))
                begin
                    state_next = S_RESULT;
                end
            end
            S_GATHER:
            begin
                if (old_done)
                begin
                    state_next = S_RLOAD;
                end
            end
            S_RLOAD:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = (op_reg == OP_INSERT) ? S_PSTART : S_RESULT;
                end
                else
                begin
                    state_next = S_RSTART;
                end
            end
            S_RSTART:
            begin
                state_next = S_RPROBE;
            end
            S_RPROBE:
            begin
                if (tag_empty)
                begin
                    state_next = S_RLOAD;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        ib_next         = ib_reg;
        gen_next        = gen_reg;
        live_next       = live_reg;
        empty_next      = empty_reg;
        c_next          = c_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        hash_next       = hash_reg;
        val_next        = val_reg;
        nb_next         = nb_reg;
        ix_next         = ix_reg;
        cnt_next        = cnt_reg;
        pt_next         = pt_reg;
        tomb_v_next     = tomb_v_reg;
        tomb_ix_next    = tomb_ix_reg;
        g_next          = g_reg;
        paddr_next      = paddr_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        rkv_next        = rkv_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        tag_we          = 1'b0;
        tag_waddr       = ix_reg;
        tag_wdata       = TAG_EMPTY;
        kv_we           = 1'b0;
        kv_waddr        = ix_reg;
        kv_wdata        = {key_reg, val_reg};
        sc_we           = 1'b0;
        rd_addr         = ix_reg;

        unique case (state_reg)
            S_INIT:
            begin
                tag_we    = 1'b1;
                tag_waddr = c_reg[AW-1:0];
                c_next    = c_reg + CW'(1);
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = op_t'(opcode);
                    key_next  = key[KW-1:0];
                    hash_next = key_hash;
                    val_next  = value_in[VW-1:0];
                end
            end
            S_DISPATCH:
            begin
                res_status_next = ST_OK;
                res_value_next  = '0;
                g_next          = '0;
                pend_next       = 1'b0;
                n_next          = '0;
                nb_next         = grow ? ib_reg + IBW'(1) : ib_reg;
            end
            S_PSTART:
            begin
                pt_next     = t_w;
                ix_next     = pstart_ix;
                rd_addr     = pstart_ix;
                cnt_next    = '0;
                tomb_v_next = 1'b0;
            end
            S_PROBE:
            begin
                // read the next slot ahead; dropped if the probe ends here
                rd_addr  = ix_adv;
                ix_next  = ix_adv;
                cnt_next = cnt_reg + AW'(1);
                case (op_reg)
                    OP_FIND:
                    begin
                        if (key_match)
                        begin
                            res_value_next = kv_q[VW-1:0];
                        end
                        else if (probe_end)
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (key_match)
                        begin
                            tag_we    = 1'b1;
                            tag_wdata = TAG_TOMB;
                            live_next = live_dec;
                            c_next    = '0;
                            nb_next   = ib_reg - IBW'(1);
                        end
                        else if (probe_end)
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (ins_tomb_now)
                        begin
                            tomb_v_next  = 1'b1;
                            tomb_ix_next = ix_reg;
                        end
                        if (key_match)
                        begin
                            kv_we = 1'b1;
                        end
                        else if (probe_end)
                        begin
                            if (have_tomb)
                            begin
                                tag_we    = 1'b1;
                                tag_waddr = tomb_v_reg ? tomb_ix_reg : ix_reg;
                                tag_wdata = pt_reg;
                                kv_we     = 1'b1;
                                kv_waddr  = tomb_v_reg ? tomb_ix_reg : ix_reg;
                                live_next = live_reg + CW'(1);
                            end
                            else if (take_empty)
                            begin
                                tag_we     = 1'b1;
                                tag_wdata  = pt_reg;
                                kv_we      = 1'b1;
                                live_next  = live_reg + CW'(1);
                                empty_next = empty_reg - CW'(1);
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_CLEAR:
            begin
                tag_we    = 1'b1;
                tag_waddr = c_reg[AW-1:0];
                c_next    = c_reg + CW'(1);
                if (c_reg == size_w - CW'(1))
                begin
                    ib_next    = IB_MIN;
                    gen_next   = 1'b0;
                    empty_next = EMPTY_RST;
                end
            end
            S_GATHER:
            begin
                // read slot g while the slot read last cycle is cleared and, if live, copied
                rd_addr = g_reg[AW-1:0];
                if (g_reg != size_w)
                begin
                    g_next     = g_reg + CW'(1);
                    pend_next  = 1'b1;
                    paddr_next = g_reg[AW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    tag_we    = 1'b1;
                    tag_waddr = paddr_reg;
                    if (tag_q[TAG_LIVE_BIT])
                    begin
                        sc_we  = 1'b1;
                        n_next = n_reg + CW'(1);
                    end
                end
                if (old_done)
                begin
                    ib_next  = nb_reg;
                    gen_next = !gen_reg;
                    k_next   = '0;
                end
            end
            S_RLOAD:
            begin
                if (k_reg == n_reg)
                begin
                    live_next  = n_reg;
                    empty_next = size_w - n_reg;
                end
            end
            S_RSTART:
            begin
                pt_next  = rt_w;
                ix_next  = rstart_ix;
                rkv_next = sc_q[KVW-1:0];
                rd_addr  = rstart_ix;
            end
            S_RPROBE:
            begin
                if (tag_empty)
                begin
                    tag_we    = 1'b1;
                    tag_wdata = pt_reg;
                    kv_we     = 1'b1;
                    kv_wdata  = rkv_reg;
                    k_next    = k_reg + CW'(1);
                end
                else
                begin
                    ix_next = ix_adv;
                    rd_addr = ix_adv;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_count_next  = live_reg;
                end
            end
            default:
            begin
                c_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ib_reg        <= IB_MIN;
            gen_reg       <= 1'b0;
            live_reg      <= '0;
            empty_reg     <= EMPTY_RST;
            c_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ib_reg        <= ib_next;
            gen_reg       <= gen_next;
            live_reg      <= live_next;
            empty_reg     <= empty_next;
            c_reg         <= c_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        hash_reg       <= hash_next;
        val_reg        <= val_next;
        nb_reg         <= nb_next;
        ix_reg         <= ix_next;
        cnt_reg        <= cnt_next;
        pt_reg         <= pt_next;
        tomb_v_reg     <= tomb_v_next;
        tomb_ix_reg    <= tomb_ix_next;
        g_reg          <= g_next;
        paddr_reg      <= paddr_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        rkv_reg        <= rkv_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign value_out   = 32'(out_value_reg);
    assign entry_count = out_count_reg;

    a_ib_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ib_reg >= IB_MIN) && (ib_reg <= IB_MAX))
        else $error("table size out of range");

    a_live_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg < size_w)
        else $error("live count reached table size");

    a_slot_accounting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            (({1'b0, empty_reg} + {1'b0, live_reg}) <= {1'b0, size_w}) && (empty_reg != '0))
        else $error("empty and live counts disagree with table size");

    a_result_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DISPATCH))
        else $error("accepted item not dispatched");

endmodule
